[sv/wmf_pkg.sv]
`timescale 1ns / 1ps
// wmf_pkg: types and constants shared by the windowed median filter.
// No dependencies.
package wmf_pkg;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2,
    REG_CHANNEL = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_GATHER,
    ST_DRAIN,
    ST_SCAN,
    ST_OUT
  } state_e;

  localparam int unsigned NumBins = 256;
  localparam int unsigned BinW    = 8;

  typedef struct packed {
    logic [0:0] func;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] red_sample;
    logic [7:0] green_sample;
    logic [7:0] blue_sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0] median_value;
    logic [7:0] out_x;
    logic [7:0] out_y;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic setup;      // latch query, compute window bounds
    logic clear;      // zero one histogram bin
    logic gather;     // issue one window read
    logic scan;       // examine one histogram bin
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic gather_done;
    logic pipe_empty;
    logic found;
  } dp_sts_t;

endpackage

[sv/windowed_median_filter.sv]
`timescale 1ns / 1ps
// Windowed median filter: a load word stores one channel sample in the frame store. A query
// word clears the 256 histogram bins, reads each window pixel from the frame store (n, at
// most (2R+1)^2 after clipping) and counts it in the histogram, drains the histogram
// pipeline, and scans histogram bins up to the median m; the result is then presented and
// may be stalled. One query at a time; input is stalled meanwhile.
// Depends on wmf_pkg, wmf_ctrl, wmf_datapath and wmf_ram.
module windowed_median_filter import wmf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);
  logic [3:0] radius_q;
  logic [8:0] width_q, height_q;
  logic [1:0] chan_q;
  logic       load;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd1;
      width_q  <= 9'd256;
      height_q <= 9'd256;
      chan_q   <= CH_RED;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_RADIUS:  radius_q <= cfg_data_i[3:0];
        REG_WIDTH:   width_q  <= cfg_data_i;
        REG_HEIGHT:  height_q <= cfg_data_i;
        REG_CHANNEL: chan_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  wmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func[0]),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .load_o      (load),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wmf_datapath #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT),
    .MaxRadius (MAX_RADIUS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_data_i),
    .load_i     (load),
    .radius_i   (radius_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .chan_i     (chan_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_data_o)
  );
endmodule

[sv/wmf_ram.sv]
`timescale 1ns / 1ps
// wmf_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module wmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[sv/wmf_datapath.sv]
`timescale 1ns / 1ps
// wmf_datapath: frame store, window walker, histogram and median scan.
// Depends on wmf_pkg and wmf_ram.
module wmf_datapath import wmf_pkg::*; #(
  parameter int unsigned MaxWidth  = 256,
  parameter int unsigned MaxHeight = 256,
  parameter int unsigned MaxRadius = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  logic      load_i,
  input  logic [3:0] radius_i,
  input  logic [8:0] width_i,
  input  logic [8:0] height_i,
  input  logic [1:0] chan_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_word_t out_word_o
);
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned CW = XW + 1;
  localparam int unsigned HW = YW + 1;
  // window count bound (2R+1)^2
  localparam int unsigned NW = $clog2((2 * MaxRadius + 1) * (2 * MaxRadius + 1) + 1);
  localparam int unsigned RW = $clog2(MaxRadius + 1);

  // effective sizes
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW:0]   r_eff;
  logic [12:0]   w_ext, h_ext;

  assign w_ext = 13'(width_i);
  assign h_ext = 13'(height_i);
  always_comb begin
    if (width_i == '0) w_eff = CW'(1);
    else if (w_ext > 13'(MaxWidth)) w_eff = CW'(MaxWidth);
    else w_eff = CW'(width_i);
    if (height_i == '0) h_eff = HW'(1);
    else if (h_ext > 13'(MaxHeight)) h_eff = HW'(MaxHeight);
    else h_eff = HW'(height_i);
    if (32'(radius_i) > MaxRadius) r_eff = (RW+1)'(MaxRadius);
    else r_eff = (RW+1)'(radius_i);
  end

  // frame store
  logic [7:0]    sample;
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_rdata;

  always_comb begin
    case (chan_i)
      CH_RED:   sample = in_word_i.red_sample;
      CH_GREEN: sample = in_word_i.green_sample;
      default:  sample = in_word_i.blue_sample;
    endcase
  end

  assign st_we = load_i && (32'(in_word_i.pos_x) < MaxWidth)
                        && (32'(in_word_i.pos_y) < MaxHeight);
  assign st_waddr = {YW'(in_word_i.pos_y), XW'(in_word_i.pos_x)};

  wmf_ram #(.Width(8), .Depth(2 ** AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (sample),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // window bounds, set up once per query
  logic [7:0]    qx_q, qy_q;
  logic [CW-1:0] x0_q, x1_q, cx_q;
  logic [HW-1:0] y1_q, cy_q;
  logic [NW-1:0] n_q;
  logic          walk_done_q;

  logic [CW-1:0] xc, x0_d, x1_d, xr;
  logic [HW-1:0] yc, y0_d, y1_d, yr;
  logic [CW:0]   xsum;
  logic [HW:0]   ysum;

  always_comb begin
    xc = (32'(in_word_i.pos_x) >= 32'(w_eff)) ? w_eff - CW'(1) : CW'(in_word_i.pos_x);
    yc = (32'(in_word_i.pos_y) >= 32'(h_eff)) ? h_eff - HW'(1) : HW'(in_word_i.pos_y);
    xr = CW'(r_eff);
    yr = HW'(r_eff);
    x0_d = (xc > xr) ? xc - xr : '0;
    y0_d = (yc > yr) ? yc - yr : '0;
    xsum = (CW+1)'(xc) + (CW+1)'(xr);
    ysum = (HW+1)'(yc) + (HW+1)'(yr);
    x1_d = (xsum < (CW+1)'(w_eff)) ? CW'(xsum) : w_eff - CW'(1);
    y1_d = (ysum < (HW+1)'(h_eff)) ? HW'(ysum) : h_eff - HW'(1);
  end

  assign st_raddr = {YW'(cy_q), XW'(cx_q)};

  // histogram: read-modify-write, second RAM behind the registered frame store read
  logic          rd_v1_q;
  logic [7:0]    bin_a_q;        // bin addr of pending increment
  logic          inc_v_q;
  logic [NW-1:0] hist_rdata;
  logic          h_we;
  logic [7:0]    h_waddr, h_raddr;
  logic [NW-1:0] h_wdata;
  logic [8:0]    clr_q;
  logic [7:0]    scan_q;
  logic [NW-1:0] run_q;
  logic [NW-1:0] target;
  logic [NW-1:0] inc_val;
  logic          fwd;
  logic [NW-1:0] last_val_q;
  logic [7:0]    last_bin_q;
  logic          last_v_q;
  logic [7:0]    med_q;
  logic          found_q;
  logic          scan_v_q;

  // pixel value arrives the cycle after the store read: then read hist,
  // next cycle write back +1 (forwarding consecutive same-bin hits)
  always_comb begin
    fwd = last_v_q && (last_bin_q == bin_a_q);
    inc_val = (fwd ? last_val_q : hist_rdata) + NW'(1);
  end

  always_comb begin
    h_we = 1'b0;
    h_waddr = bin_a_q;
    h_wdata = inc_val;
    if (cmd_i.clear) begin
      h_we = 1'b1;
      h_waddr = clr_q[7:0];
      h_wdata = '0;
    end else if (inc_v_q) begin
      h_we = 1'b1;
    end
    h_raddr = cmd_i.scan ? scan_q : st_rdata;
  end

  wmf_ram #(.Width(NW), .Depth(NumBins)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (hist_rdata)
  );

  assign target = NW'((32'(n_q) + 1) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v1_q <= 1'b0;
      inc_v_q <= 1'b0;
      last_v_q <= 1'b0;
      walk_done_q <= 1'b0;
      clr_q <= '0;
      found_q <= 1'b0;
      scan_v_q <= 1'b0;
    end else begin
      rd_v1_q <= cmd_i.gather && !walk_done_q;
      inc_v_q <= rd_v1_q;
      last_v_q <= inc_v_q;
      if (cmd_i.setup) begin
        walk_done_q <= 1'b0;
        clr_q <= '0;
        found_q <= 1'b0;
        scan_v_q <= 1'b0;
      end else begin
        if (cmd_i.clear) clr_q <= clr_q + 9'd1;
        if (cmd_i.gather && !walk_done_q && cx_q == x1_q && cy_q == y1_q)
          walk_done_q <= 1'b1;
        scan_v_q <= cmd_i.scan && !found_q;
        if (scan_v_q && !found_q && (run_q + hist_rdata >= target)) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_a_q <= st_rdata;
    last_bin_q <= bin_a_q;
    last_val_q <= inc_val;
    if (cmd_i.setup) begin
      qx_q <= in_word_i.pos_x;
      qy_q <= in_word_i.pos_y;
      x0_q <= x0_d; x1_q <= x1_d; y1_q <= y1_d;
      cx_q <= x0_d; cy_q <= y0_d;
      n_q <= '0;
      scan_q <= '0;
      run_q <= '0;
    end else begin
      if (cmd_i.gather && !walk_done_q) begin
        n_q <= n_q + NW'(1);
        if (cx_q == x1_q) begin
          cx_q <= x0_q;
          cy_q <= cy_q + HW'(1);
        end else begin
          cx_q <= cx_q + CW'(1);
        end
      end
      if (cmd_i.scan && !found_q) scan_q <= scan_q + 8'd1;
      if (scan_v_q && !found_q) begin
        run_q <= run_q + hist_rdata;
        med_q <= scan_q - 8'd1;
      end
    end
  end

  // the store read of rd_v1 lands at st_rdata while rd_v1 is high;
  // the hist read address during that cycle is st_rdata
  assign sts_o.clear_done  = (clr_q == 9'(NumBins - 1));
  assign sts_o.gather_done = walk_done_q;
  assign sts_o.pipe_empty  = !rd_v1_q && !inc_v_q;
  assign sts_o.found       = found_q;

  assign out_word_o.median_value = med_q;
  assign out_word_o.out_x = qx_q;
  assign out_word_o.out_y = qy_q;
endmodule

[sv/wmf_ctrl.sv]
`timescale 1ns / 1ps
// wmf_ctrl: sequencer for load words and query words (clear, gather, drain, scan, present).
// Depends on wmf_pkg.
module wmf_ctrl import wmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic     load_o,
  output dp_cmd_t  cmd_o,
  input  dp_sts_t  sts_i
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_func_i == FUNC_QUERY) begin
            cmd_o.setup = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            load_o = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = ST_GATHER;
      end
      ST_GATHER: begin
        cmd_o.gather = 1'b1;
        if (sts_i.gather_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
